// ===== rtl/core/asgd_pkg.sv =====
// asgd_pkg: shared types, constants and helpers of the Adam/SGD update unit.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package asgd_pkg;

    localparam int DEF_WEIGHT_ENTRIES = 4096;
    localparam int DEF_BIAS_ENTRIES   = 256;

    localparam logic [24:0] ONE_Q24  = 25'h100_0000;
    localparam logic [23:0] HALF_Q24 = 24'h80_0000;

    // root and divide pipeline shape
    localparam int SQ_STAGES  = 7;
    localparam int SQ_STEPS   = 4;
    localparam int ROOT_W     = SQ_STAGES * SQ_STEPS;
    localparam int DIV_STAGES = 9;
    localparam int DIV_STEPS  = 4;
    localparam int QUO_W      = DIV_STAGES * DIV_STEPS;
    localparam int NUM_W      = 56;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_RATE      = 3'd1,
        REG_BETA_ONE  = 3'd2,
        REG_BETA_TWO  = 3'd3,
        REG_EPSILON   = 3'd4,
        REG_FIRST_COR = 3'd5,
        REG_SECND_COR = 3'd6,
        REG_BIAS_EN   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] m;
        logic        [31:0] v;
    } moment_t;

    typedef struct packed {
        logic        rd_en;
        logic        rd_bias;
        logic [11:0] rd_idx;
        logic        wr_en;
        logic        wr_bias;
        logic [11:0] wr_idx;
        moment_t     wr_data;
    } mem_req_t;

    typedef struct packed {
        logic               fix;
        logic               neg;
        logic signed [33:0] step_fix;
        logic signed [31:0] cur;
    } side_t;

    typedef struct packed {
        logic             zero;
        logic             ovf;
        logic [QUO_W-1:0] q;
        side_t            side;
    } div_res_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_u32(input logic [63:0] x);
        return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/adam_sgd_parameter_update_unit.sv =====
// adam_sgd_parameter_update_unit: top level of the per-parameter optimiser step.
// Uses asgd_pkg, asgd_moment_mem and asgd_root_div.
`default_nettype none

// Channel   Dir  Handshake                    Contents
// s_*       in   s_tvalid/s_tready            one parameter word: index, gradient, value
// m_*       out  m_tvalid/m_tready            updated value, Q8.24 saturated
// APB       in   psel/penable/pwrite, pready  eight configuration registers
//
// One word per cycle while s_tready holds (no hazard, sweep or stall); each word passes
// 7 multiply stages, 7 root stages, one epsilon stage, 9 divide stages and output to m_tvalid.
// An Adam word for an entry still in its read-modify-write window (the four
// stages up to moment write-back) is held off until that write lands.
// After reset a zeroing sweep of max(weight, bias) entries (4096 by default)
// runs before s_tready rises; register writes are taken throughout.
// A full output register with m_tready low stalls the pipe only once its last
// stage holds a word.

module adam_sgd_parameter_update_unit #(
    parameter int WEIGHT_ENTRIES = asgd_pkg::DEF_WEIGHT_ENTRIES,
    parameter int BIAS_ENTRIES   = asgd_pkg::DEF_BIAS_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [11:0] entry_index, [43:12] gradient, [75:44] current_value, [79:76] zero
    input  wire logic [79:0] s_tdata,
    // [0] is_bias
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] new_value
    output logic [31:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import asgd_pkg::*;

    typedef struct packed {
        logic               adam;
        logic               plain;
        logic               bias;
        logic [11:0]        idx;
        logic signed [31:0] cur;
    } ctl_t;

    // configuration
    logic        mode_reg;
    logic [23:0] rate_reg;
    logic [23:0] beta_one_reg;
    logic [23:0] beta_two_reg;
    logic [23:0] eps_reg;
    logic [31:0] cor_one_reg;
    logic [31:0] cor_two_reg;
    logic        bias_en_reg;
    logic        cfg_wr;

    // input decode
    logic               in_bias;
    logic [11:0]        in_idx;
    logic signed [31:0] in_g;
    logic signed [31:0] in_cur;
    logic               in_active;
    ctl_t               in_ctl;
    logic               hazard;
    logic               in_fire;
    logic               adv;

    // pipe stages
    logic               p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic               p5_vld_reg, p6_vld_reg, p7_vld_reg;
    ctl_t               p1_ctl_reg, p2_ctl_reg, p3_ctl_reg, p4_ctl_reg, p5_ctl_reg, p6_ctl_reg;
    logic signed [31:0] p1_g_reg;

    logic signed [57:0] p2_pm_reg, p2_pm_next;
    logic signed [57:0] p2_pg_reg, p2_pg_next;
    logic        [63:0] p2_sq_reg, p2_sq_next;
    logic signed [57:0] p2_pl_reg, p2_pl_next;
    logic        [31:0] p2_v_reg;

    logic signed [31:0] p3_m_reg, p3_m_next;
    logic        [38:0] p3_g2_reg, p3_g2_next;
    logic        [31:0] p3_v_reg;
    logic signed [33:0] p3_fix_reg, p3_fix_next;

    logic signed [31:0] p4_m_reg;
    logic        [55:0] p4_pv_reg, p4_pv_next;
    logic        [63:0] p4_pg_reg, p4_pg_next;
    logic signed [64:0] p4_pm_reg, p4_pm_next;
    logic signed [33:0] p4_fix_reg;

    logic        [31:0] p5_v_reg, p5_v_next;
    logic signed [31:0] p5_mh_reg, p5_mh_next;
    logic signed [33:0] p5_fix_reg;

    logic        [63:0] p6_pv_reg, p6_pv_next;
    logic        [55:0] p6_lr_reg, p6_lr_next;
    logic               p6_neg_reg;
    logic signed [33:0] p6_fix_reg;

    logic        [31:0] p7_vh_reg, p7_vh_next;
    logic        [55:0] p7_lr_reg;
    side_t              p7_side_reg, p7_side_next;

    mem_req_t           mreq;
    moment_t            mrd;
    logic               clearing;
    logic               rd_vld;
    div_res_t           rd_res;

    logic signed [37:0] step;
    logic [QUO_W-1:0]   qmag;
    logic signed [37:0] diff;
    logic               out_vld_reg;
    logic [31:0]        out_data_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b1;
            rate_reg     <= 24'd16777;
            beta_one_reg <= 24'd15099494;
            beta_two_reg <= 24'd16760438;
            eps_reg      <= 24'd1;
            cor_one_reg  <= 32'd16777216;
            cor_two_reg  <= 32'd16777216;
            bias_en_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_MODE:      mode_reg     <= pwdata[0];
                REG_RATE:      rate_reg     <= pwdata[23:0];
                REG_BETA_ONE:  beta_one_reg <= pwdata[23:0];
                REG_BETA_TWO:  beta_two_reg <= pwdata[23:0];
                REG_EPSILON:   eps_reg      <= pwdata[23:0];
                REG_FIRST_COR: cor_one_reg  <= pwdata;
                REG_SECND_COR: cor_two_reg  <= pwdata;
                REG_BIAS_EN:   bias_en_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_MODE:      prdata = 32'(mode_reg);
            REG_RATE:      prdata = 32'(rate_reg);
            REG_BETA_ONE:  prdata = 32'(beta_one_reg);
            REG_BETA_TWO:  prdata = 32'(beta_two_reg);
            REG_EPSILON:   prdata = 32'(eps_reg);
            REG_FIRST_COR: prdata = cor_one_reg;
            REG_SECND_COR: prdata = cor_two_reg;
            REG_BIAS_EN:   prdata = 32'(bias_en_reg);
        endcase
    end

    // ---------------- input side ----------------
    assign in_bias = s_tuser[0];
    assign in_idx  = s_tdata[11:0];
    assign in_g    = signed'(s_tdata[43:12]);
    assign in_cur  = signed'(s_tdata[75:44]);

    // out-of-range entries and disabled bias pass straight through
    assign in_active = in_bias ? (bias_en_reg && (32'(in_idx) < BIAS_ENTRIES))
                               : (32'(in_idx) < WEIGHT_ENTRIES);

    always_comb
    begin
        in_ctl.adam  = in_active && mode_reg;
        in_ctl.plain = in_active && !mode_reg;
        in_ctl.bias  = in_bias;
        in_ctl.idx   = in_idx;
        in_ctl.cur   = in_cur;
    end

    // entry still between read and write-back further down
    assign hazard = in_ctl.adam && (
        (p1_vld_reg && p1_ctl_reg.adam && p1_ctl_reg.bias == in_bias && p1_ctl_reg.idx == in_idx) ||
        (p2_vld_reg && p2_ctl_reg.adam && p2_ctl_reg.bias == in_bias && p2_ctl_reg.idx == in_idx) ||
        (p3_vld_reg && p3_ctl_reg.adam && p3_ctl_reg.bias == in_bias && p3_ctl_reg.idx == in_idx) ||
        (p4_vld_reg && p4_ctl_reg.adam && p4_ctl_reg.bias == in_bias && p4_ctl_reg.idx == in_idx));

    // pipe moves unless the last stage holds a word the output cannot take
    assign adv      = !rd_vld || !out_vld_reg || m_tready;
    assign s_tready = adv && !clearing && !hazard;
    assign in_fire  = s_tvalid && s_tready;

    // ---------------- moment store ----------------
    always_comb
    begin
        mreq.rd_en     = adv;
        mreq.rd_bias   = in_bias;
        mreq.rd_idx    = in_idx;
        mreq.wr_en     = adv && p4_vld_reg && p4_ctl_reg.adam;
        mreq.wr_bias   = p4_ctl_reg.bias;
        mreq.wr_idx    = p4_ctl_reg.idx;
        mreq.wr_data.m = p4_m_reg;
        mreq.wr_data.v = p5_v_next;
    end

    asgd_moment_mem #(
        .WEIGHT_ENTRIES (WEIGHT_ENTRIES),
        .BIAS_ENTRIES   (BIAS_ENTRIES)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mreq),
        .rd_data  (mrd),
        .clearing (clearing)
    );

    // ---------------- stage arithmetic ----------------
    // products: b1*m, (1-b1)*g, g^2, lr*g
    always_comb
    begin
        logic signed [25:0] b1s;
        logic signed [25:0] omb1;
        logic signed [25:0] lrs;
        logic        [31:0] gmag;
        b1s        = signed'({2'b00, beta_one_reg});
        omb1       = signed'(26'(ONE_Q24) - 26'(beta_one_reg));
        lrs        = signed'({2'b00, rate_reg});
        gmag       = p1_g_reg[31] ? 32'(-p1_g_reg) : 32'(p1_g_reg);
        p2_pm_next = 58'(b1s) * 58'(mrd.m);
        p2_pg_next = 58'(omb1) * 58'(p1_g_reg);
        p2_sq_next = 64'(gmag) * 64'(gmag);
        p2_pl_next = 58'(lrs) * 58'(p1_g_reg);
    end

    // new first moment, rounded g^2, plain-mode step
    always_comb
    begin
        logic signed [58:0] msum;
        logic        [63:0] sqr;
        logic signed [57:0] plr;
        msum        = 59'(p2_pm_reg) + 59'(p2_pg_reg) + 59'sd8388608;
        p3_m_next   = sat_s32(64'(signed'(msum[58:24])));
        sqr         = p2_sq_reg + 64'(HALF_Q24);
        p3_g2_next  = sqr[62:24];
        plr         = p2_pl_reg + 58'sd8388608;
        p3_fix_next = p2_ctl_reg.plain ? plr[57:24] : 34'sd0;
    end

    // b2*v, (1-b2)*g2, m'*c1
    always_comb
    begin
        logic [24:0] omb2;
        omb2       = ONE_Q24 - 25'(beta_two_reg);
        p4_pv_next = 56'(beta_two_reg) * 56'(p3_v_reg);
        p4_pg_next = 64'(omb2) * 64'(p3_g2_reg);
        p4_pm_next = 65'(signed'({1'b0, cor_one_reg})) * 65'(p3_m_reg);
    end

    // new second moment (written back here), corrected first moment
    always_comb
    begin
        logic        [65:0] vsum;
        logic signed [65:0] hsum;
        vsum       = 66'(p4_pv_reg) + 66'(p4_pg_reg) + 66'(HALF_Q24);
        p5_v_next  = sat_u32(64'(vsum[65:24]));
        hsum       = 66'(p4_pm_reg) + 66'sd8388608;
        p5_mh_next = sat_s32(64'(signed'(hsum[65:24])));
    end

    // v'*c2, lr*|mhat|
    always_comb
    begin
        logic [31:0] mmag;
        mmag       = p5_mh_reg[31] ? 32'(-p5_mh_reg) : 32'(p5_mh_reg);
        p6_pv_next = 64'(p5_v_reg) * 64'(cor_two_reg);
        p6_lr_next = 56'(rate_reg) * 56'(mmag);
    end

    // corrected second moment
    always_comb
    begin
        logic [64:0] vh;
        vh                    = 65'(p6_pv_reg) + 65'(HALF_Q24);
        p7_vh_next            = sat_u32(64'(vh[64:24]));
        p7_side_next.fix      = !p6_ctl_reg.adam;
        p7_side_next.neg      = p6_neg_reg;
        p7_side_next.step_fix = p6_fix_reg;
        p7_side_next.cur      = p6_ctl_reg.cur;
    end

    // ---------------- pipe registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            p7_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= in_fire;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
            p7_vld_reg <= p6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ctl_reg  <= in_ctl;
            p1_g_reg    <= in_g;

            p2_ctl_reg  <= p1_ctl_reg;
            p2_pm_reg   <= p2_pm_next;
            p2_pg_reg   <= p2_pg_next;
            p2_sq_reg   <= p2_sq_next;
            p2_pl_reg   <= p2_pl_next;
            p2_v_reg    <= mrd.v;

            p3_ctl_reg  <= p2_ctl_reg;
            p3_m_reg    <= p3_m_next;
            p3_g2_reg   <= p3_g2_next;
            p3_v_reg    <= p2_v_reg;
            p3_fix_reg  <= p3_fix_next;

            p4_ctl_reg  <= p3_ctl_reg;
            p4_m_reg    <= p3_m_reg;
            p4_pv_reg   <= p4_pv_next;
            p4_pg_reg   <= p4_pg_next;
            p4_pm_reg   <= p4_pm_next;
            p4_fix_reg  <= p3_fix_reg;

            p5_ctl_reg  <= p4_ctl_reg;
            p5_v_reg    <= p5_v_next;
            p5_mh_reg   <= p5_mh_next;
            p5_fix_reg  <= p4_fix_reg;

            p6_ctl_reg  <= p5_ctl_reg;
            p6_pv_reg   <= p6_pv_next;
            p6_lr_reg   <= p6_lr_next;
            p6_neg_reg  <= p5_mh_reg[31];
            p6_fix_reg  <= p5_fix_reg;

            p7_vh_reg   <= p7_vh_next;
            p7_lr_reg   <= p6_lr_reg;
            p7_side_reg <= p7_side_next;
        end
    end

    // ---------------- root and divide ----------------
    asgd_root_div u_root_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p7_vld_reg),
        .vhat      (p7_vh_reg),
        .num       (p7_lr_reg),
        .in_side   (p7_side_reg),
        .eps       (eps_reg),
        .out_valid (rd_vld),
        .res       (rd_res)
    );

    // ---------------- final subtract and output register ----------------
    // quotient overflow, unless the denominator is zero, clamps to a step that always saturates
    always_comb
    begin
        qmag = rd_res.ovf ? {QUO_W{1'b1}} : rd_res.q;
        if (rd_res.side.fix)
            step = 38'(rd_res.side.step_fix);
        else if (rd_res.zero)
            step = 38'sd0;
        else if (rd_res.side.neg)
            step = -signed'(38'(qmag));
        else
            step = signed'(38'(qmag));
        diff = 38'(rd_res.side.cur) - step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv && rd_vld)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && rd_vld)
            out_data_reg <= sat_s32(64'(diff));
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/asgd_moment_mem.sv =====
// asgd_moment_mem: first/second moment stores for weights and biases.
// Uses asgd_pkg; registered read, zeroing sweep after reset.
`default_nettype none

module asgd_moment_mem #(
    parameter int WEIGHT_ENTRIES = asgd_pkg::DEF_WEIGHT_ENTRIES,
    parameter int BIAS_ENTRIES   = asgd_pkg::DEF_BIAS_ENTRIES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire asgd_pkg::mem_req_t req,
    output asgd_pkg::moment_t       rd_data,
    output logic                    clearing
);
    import asgd_pkg::*;

    // entry_index is 12 bits, so nothing beyond 4096 is reachable
    localparam int WD = (WEIGHT_ENTRIES > 4096) ? 4096 : WEIGHT_ENTRIES;
    localparam int BD = (BIAS_ENTRIES > 4096) ? 4096 : BIAS_ENTRIES;
    localparam int WA = (WD > 1) ? $clog2(WD) : 1;
    localparam int BA = (BD > 1) ? $clog2(BD) : 1;
    localparam int CD = (WD > BD) ? WD : BD;
    localparam int CW = (CD > 1) ? $clog2(CD) : 1;

    moment_t weight_mem [WD];
    moment_t bias_mem   [BD];

    moment_t         w_q_reg;
    moment_t         b_q_reg;
    logic            sel_reg;
    logic [CW-1:0]   clr_cnt_reg;
    logic            clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) == CD - 1)
                clearing_reg <= 1'b0;
            else
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) < WD)
                weight_mem[clr_cnt_reg[WA-1:0]] <= '0;
        end
        else if (req.wr_en && !req.wr_bias)
            weight_mem[req.wr_idx[WA-1:0]] <= req.wr_data;
        if (req.rd_en)
            w_q_reg <= weight_mem[req.rd_idx[WA-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (32'(clr_cnt_reg) < BD)
                bias_mem[clr_cnt_reg[BA-1:0]] <= '0;
        end
        else if (req.wr_en && req.wr_bias)
            bias_mem[req.wr_idx[BA-1:0]] <= req.wr_data;
        if (req.rd_en)
        begin
            b_q_reg <= bias_mem[req.rd_idx[BA-1:0]];
            sel_reg <= req.rd_bias;
        end
    end

    assign rd_data  = sel_reg ? b_q_reg : w_q_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

// ===== rtl/core/asgd_root_div.sv =====
// asgd_root_div: pipelined integer square root, epsilon add and divide.
// Uses asgd_pkg; carries item sideband alongside, moves on adv only.
`default_nettype none

module asgd_root_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic [31:0]               vhat,
    input  wire logic [asgd_pkg::NUM_W-1:0] num,
    input  wire asgd_pkg::side_t           in_side,
    input  wire logic [23:0]               eps,
    output logic                           out_valid,
    output asgd_pkg::div_res_t             res
);
    import asgd_pkg::*;

    typedef struct packed {
        logic [55:0]       x;
        logic [30:0]       rem;
        logic [ROOT_W-1:0] root;
        logic [NUM_W-1:0]  num;
        side_t             side;
    } sq_t;

    typedef struct packed {
        logic [29:0]      rem;
        logic [QUO_W-1:0] lo;
        logic [QUO_W-1:0] q;
        logic [28:0]      den;
        logic             zero;
        logic             ovf;
        side_t            side;
    } dv_t;

    function automatic sq_t sq_stage(input sq_t a);
        sq_t         r;
        logic [30:0] t;
        r = a;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            r.rem = {r.rem[28:0], r.x[55:54]};
            t     = {1'b0, r.root, 2'b01};
            if (r.rem >= t)
            begin
                r.rem  = r.rem - t;
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end
            else
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            r.x = {r.x[53:0], 2'b00};
        end
        return r;
    endfunction

    function automatic dv_t dv_stage(input dv_t a);
        dv_t r;
        r = a;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r.rem = {r.rem[28:0], r.lo[QUO_W-1]};
            r.lo  = {r.lo[QUO_W-2:0], 1'b0};
            if (r.rem >= {1'b0, r.den})
            begin
                r.rem = r.rem - {1'b0, r.den};
                r.q   = {r.q[QUO_W-2:0], 1'b1};
            end
            else
                r.q = {r.q[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_t                   sq_in;
    sq_t                   sq_reg [SQ_STAGES];
    sq_t                   sq_nx  [SQ_STAGES];
    logic [SQ_STAGES-1:0]  sq_vld_reg;
    dv_t                   dn_next;
    dv_t                   dn_reg;
    logic                  dn_vld_reg;
    dv_t                   dv_reg [DIV_STAGES];
    dv_t                   dv_nx  [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_vld_reg;
    logic [28:0]           den;

    always_comb
    begin
        sq_in.x    = {vhat, 24'd0};
        sq_in.rem  = '0;
        sq_in.root = '0;
        sq_in.num  = num;
        sq_in.side = in_side;
    end

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_sq
        if (s == 0)
        begin : g_first
            assign sq_nx[s] = sq_stage(sq_in);
        end
        else
        begin : g_rest
            assign sq_nx[s] = sq_stage(sq_reg[s-1]);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                sq_reg[s] <= sq_nx[s];
        end
    end

    // denominator and quotient overflow check
    assign den = {1'b0, sq_reg[SQ_STAGES-1].root} + 29'(eps);

    always_comb
    begin
        dn_next.den  = den;
        dn_next.zero = (den == 29'd0);
        dn_next.ovf  = (29'(sq_reg[SQ_STAGES-1].num[NUM_W-1:QUO_W]) >= den);
        dn_next.rem  = 30'(sq_reg[SQ_STAGES-1].num[NUM_W-1:QUO_W]);
        dn_next.lo   = sq_reg[SQ_STAGES-1].num[QUO_W-1:0];
        dn_next.q    = '0;
        dn_next.side = sq_reg[SQ_STAGES-1].side;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dn_reg <= dn_next;
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_dv
        if (s == 0)
        begin : g_first
            assign dv_nx[s] = dv_stage(dn_reg);
        end
        else
        begin : g_rest
            assign dv_nx[s] = dv_stage(dv_reg[s-1]);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[s] <= dv_nx[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= '0;
            dn_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
        end
        else if (adv)
        begin
            sq_vld_reg <= {sq_vld_reg[SQ_STAGES-2:0], in_valid};
            dn_vld_reg <= sq_vld_reg[SQ_STAGES-1];
            dv_vld_reg <= {dv_vld_reg[DIV_STAGES-2:0], dn_vld_reg};
        end
    end

    assign out_valid = dv_vld_reg[DIV_STAGES-1];

    always_comb
    begin
        res.zero = dv_reg[DIV_STAGES-1].zero;
        res.ovf  = dv_reg[DIV_STAGES-1].ovf;
        res.q    = dv_reg[DIV_STAGES-1].q;
        res.side = dv_reg[DIV_STAGES-1].side;
    end

endmodule

`default_nettype wire

// ===== verif/tb_adam_sgd_parameter_update_unit.sv =====
// Self-checking bench for adam_sgd_parameter_update_unit: directed table, then
// randomised phases under several register settings. Depends on asgd_pkg and the RTL.
`default_nettype none

module tb_adam_sgd_parameter_update_unit;
    import asgd_pkg::*;

    localparam int LIMIT  = 400000;
    localparam int N_PH   = 7;
    localparam int PH_LEN = 70;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic        mode;
        logic [23:0] rate;
        logic [23:0] b1;
        logic [23:0] b2;
        logic [23:0] eps;
        logic [31:0] c1;
        logic [31:0] c2;
        logic        ben;
    } opt_cfg_t;

    typedef struct {
        logic               bias;
        logic [11:0]        idx;
        logic signed [31:0] grad;
        logic signed [31:0] cur;
        bit                 known;
        logic signed [31:0] want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;     // [11:0] index, [43:12] gradient, [75:44] value
    logic [0:0]  s_tuser = '0;     // [0] is_bias
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] new_value
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adam_sgd_parameter_update_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bench copy of the block's registers and moment stores
    opt_cfg_t           cfg;
    logic signed [31:0] w_first  [DEF_WEIGHT_ENTRIES];
    logic        [31:0] w_second [DEF_WEIGHT_ENTRIES];
    logic signed [31:0] b_first  [DEF_BIAS_ENTRIES];
    logic        [31:0] b_second [DEF_BIAS_ENTRIES];

    logic signed [31:0] expected_values[$];
    int  errors = 0;
    int  cycles = 0;
    int  words_in = 0;
    int  words_out = 0;
    bit  quiet = 1'b0;

    function automatic logic signed [31:0] clip_signed(input wide_t x);
        if (x > 128'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (x < -128'sd2147483648)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [31:0] clip_unsigned(input wide_t x);
        return (x > 128'sd4294967295) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic wide_t int_root(input wide_t x);
        wide_t r;
        wide_t b;
        r = 0;
        b = 128'sd1 <<< 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // moment update plus corrected step, Q.24
    function automatic wide_t moment_step(inout logic signed [31:0] m,
                                          inout logic [31:0] v, input wide_t g);
        wide_t one, half, b1, b2, mm, vv, mag, g2, mn, vn, mhat, vhat, den, q;
        one  = 128'sd16777216;
        half = 128'sd8388608;
        b1   = cfg.b1;
        b2   = cfg.b2;
        mm   = m;
        vv   = v;
        mn   = clip_signed((b1 * mm + (one - b1) * g + half) >>> 24);
        mag  = (g < 0) ? -g : g;
        g2   = (mag * mag + half) >>> 24;
        vn   = clip_unsigned((b2 * vv + (one - b2) * g2 + half) >>> 24);
        m    = mn[31:0];
        v    = vn[31:0];
        mhat = clip_signed((mn * wide_t'(cfg.c1) + half) >>> 24);
        vhat = clip_unsigned((vn * wide_t'(cfg.c2) + half) >>> 24);
        den  = int_root(vhat <<< 24) + wide_t'(cfg.eps);
        if (den == 0)
            return 0;
        q = (wide_t'(cfg.rate) * ((mhat < 0) ? -mhat : mhat)) / den;
        return (mhat < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] next_param_value(input logic bias,
            input logic [11:0] idx, input logic signed [31:0] grad,
            input logic signed [31:0] cur);
        wide_t g, c, st;
        bit    live;
        g  = grad;
        c  = cur;
        st = 0;
        live = bias ? (cfg.ben && idx < DEF_BIAS_ENTRIES) : (idx < DEF_WEIGHT_ENTRIES);
        if (live)
        begin
            if (!cfg.mode)
                st = (wide_t'(cfg.rate) * g + 128'sd8388608) >>> 24;
            else if (bias)
                st = moment_step(b_first[idx], b_second[idx], g);
            else
                st = moment_step(w_first[idx], w_second[idx], g);
        end
        return clip_signed(c - st);
    endfunction

    task automatic reg_write(input reg_idx_t r, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(input opt_cfg_t c);
        reg_write(REG_MODE, {31'd0, c.mode});
        reg_write(REG_RATE, {8'd0, c.rate});
        reg_write(REG_BETA_ONE, {8'd0, c.b1});
        reg_write(REG_BETA_TWO, {8'd0, c.b2});
        reg_write(REG_EPSILON, {8'd0, c.eps});
        reg_write(REG_FIRST_COR, c.c1);
        reg_write(REG_SECND_COR, c.c2);
        reg_write(REG_BIAS_EN, {31'd0, c.ben});
        cfg = c;
    endtask

    // one word onto the slave side; prediction taken at the accepting edge
    task automatic send_word(input logic bias, input logic [11:0] idx,
                             input logic signed [31:0] grad, input logic signed [31:0] cur,
                             input bit known, input logic signed [31:0] want);
        logic signed [31:0] p;
        while (!quiet && $urandom_range(0, 99) < 10)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= bias;
        s_tdata  <= {4'd0, cur, grad, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        p = next_param_value(bias, idx, grad, cur);
        expected_values.push_back(known ? want : p);
        words_in++;
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // master-side back-pressure
    always @(negedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 10);

    // result checker
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
            begin
                $error("new_value: unexpected word, actual %0d", $signed(m_tdata));
                errors++;
            end
            else
            begin
                if (m_tdata !== expected_values[0])
                begin
                    $error("new_value: expected %0d, actual %0d",
                           expected_values[0], $signed(m_tdata));
                    errors++;
                end
                void'(expected_values.pop_front());
            end
            words_out++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    row_t     dir_rows[$];
    opt_cfg_t phases[N_PH];

    initial
    begin
        logic               rb;
        logic [11:0]        ri;
        logic signed [31:0] rg;
        logic signed [31:0] rc;
        int                 k;

        for (k = 0; k < DEF_WEIGHT_ENTRIES; k++)
        begin
            w_first[k]  = '0;
            w_second[k] = '0;
        end
        for (k = 0; k < DEF_BIAS_ENTRIES; k++)
        begin
            b_first[k]  = '0;
            b_second[k] = '0;
        end
        cfg = '{1'b1, 24'd16777, 24'd15099494, 24'd16760438, 24'd1,
                32'd16777216, 32'd16777216, 1'b1};

        // directed rows under reset settings and fresh moments
        // zero gradient on clean entry, out-of-range bias, extremes
        dir_rows.push_back('{1'b0, 12'd0,    32'sd0,          32'sd123,        1, 32'sd123});
        dir_rows.push_back('{1'b1, 12'd256,  32'sh7FFF_FFFF,  -32'sd5,         1, -32'sd5});
        dir_rows.push_back('{1'b1, 12'd4095, 32'sh8000_0000,  32'sh7FFF_FFFF,  1,
                             32'sh7FFF_FFFF});
        dir_rows.push_back('{1'b0, 12'd4095, 32'sd0,          32'sh8000_0000,  1,
                             32'sh8000_0000});
        dir_rows.push_back('{1'b0, 12'd1,    32'sh7FFF_FFFF,  32'sh8000_0000,  0, 0});
        dir_rows.push_back('{1'b0, 12'd2,    32'sh8000_0000,  32'sh7FFF_FFFF,  0, 0});
        dir_rows.push_back('{1'b0, 12'd3,    32'sd1,          32'sd0,          0, 0});
        dir_rows.push_back('{1'b0, 12'd4,    -32'sd1,         32'sd0,          0, 0});
        dir_rows.push_back('{1'b1, 12'd0,    32'sd16777216,   32'sd16777216,   0, 0});
        dir_rows.push_back('{1'b1, 12'd255,  -32'sd16777216,  -32'sd16777216,  0, 0});
        // same entry back to back: read-modify-write hold-off
        for (k = 0; k < 4; k++)
            dir_rows.push_back('{1'b0, 12'd5, 32'sd8388608, 32'sd1000, 0, 0});
        dir_rows.push_back('{1'b0, 12'd1,    32'sh7FFF_FFFF,  32'sd0,          0, 0});
        dir_rows.push_back('{1'b1, 12'd255,  32'sd0,          32'sd77,         0, 0});

        // mode, rate, b1, b2, eps, c1, c2, bias enable
        phases[0] = '{1'b1, 24'd16777, 24'd15099494, 24'd16760438, 24'd1,
                      32'd16777216, 32'd16777216, 1'b1};
        phases[1] = '{1'b0, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 32'd0, 32'd0, 1'b1};
        // betas zero and epsilon zero: zero gradient gives zero denominator
        phases[2] = '{1'b1, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};
        phases[3] = '{1'b1, 24'd1677721, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                      32'd167772160, 32'd1, 1'b1};
        phases[4] = '{1'b0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0};
        phases[5] = '{1'b1, 24'd838860, 24'd13421772, 24'd16609443, 24'd0,
                      32'd33554432, 32'd50331648, 1'b1};
        phases[6] = '{1'b1, 24'd16777, 24'd15099494, 24'd16760438, 24'd1,
                      32'd16777216, 32'd16777216, 1'b1};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].bias, dir_rows[k].idx, dir_rows[k].grad,
                      dir_rows[k].cur, dir_rows[k].known, dir_rows[k].want);
        drain();

        for (int ph = 0; ph < N_PH; ph++)
        begin
            load_cfg(phases[ph]);
            quiet = (ph == N_PH - 1);
            for (k = 0; k < PH_LEN; k++)
            begin
                rb = ($urandom_range(0, 3) == 0);
                // mostly a few hot entries so the moments build up
                case ($urandom_range(0, 9))
                    0, 1:    ri = $urandom_range(0, 4095);
                    2:       ri = $urandom_range(240, 300);
                    default: ri = $urandom_range(0, 15);
                endcase
                case ($urandom_range(0, 9))
                    0:       rg = 32'sd0;
                    1, 2, 3: rg = $urandom;
                    default: rg = $signed($urandom_range(0, 33554432)) - 32'sd16777216;
                endcase
                case ($urandom_range(0, 9))
                    0:       rc = 32'sh7FFF_FFFF;
                    1:       rc = 32'sh8000_0000;
                    default: rc = $urandom;
                endcase
                send_word(rb, ri, rg, rc, 0, 0);
            end
            // hold the sender until every result is back
            drain();
        end

        quiet = 1'b0;
        $display("%0d words sent, %0d results checked over %0d register settings",
                 words_in, words_out, N_PH + 1);
        $display("covered plain and Adam modes, bias on/off, range misses, saturation");
        if (errors == 0 && expected_values.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
